// File: hw/rtl/bba_pkg.sv
package bba_pkg;

   // Fixed field widths
   localparam int CFG_W    = 13;
   localparam int BLK_W    = 12;
   localparam int STATUS_W = 2;

   // Parameter defaults
   localparam int MAX_BLOCKS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   // Register reset values
   localparam logic [CFG_W-1:0] NUM_BLOCKS_RST  = CFG_W'(4096);
   localparam logic [CFG_W-1:0] FIRST_DATA_RST  = CFG_W'(0);
   localparam logic [CFG_W-1:0] FREE_COUNT_RST  = CFG_W'(4096);
   localparam logic [CFG_W-1:0] FREE_COUNT_MAX  = {CFG_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 2'd0,
      ST_NO_SPACE      = 2'd1,
      ST_INVALID_BLOCK = 2'd2,
      ST_ALREADY_FREE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_NUM_BLOCKS         = 2'd0,
      CSR_DATA_START         = 2'd1,
      CSR_INITIAL_FREE_COUNT = 2'd2
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic       clr;          // zero one bitmap word, advance clear pointer
      logic       load_req;     // capture request, derive search bounds
      logic       rd;           // read bitmap word at scan pointer
      logic       alloc_commit; // set found bit, count down
      logic       free_commit;  // clear bit, count up
      logic       resp_load;    // load result register
      status_type resp_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;    // clear pointer at last word
      logic slot_free;   // result register can take a word this cycle
      logic mode;        // 1 = free request
      logic alloc_empty; // counter zero or empty search range
      logic invalid;     // block number at or beyond block count
      logic hit;         // read word has a clear bit in range
      logic scan_last;   // read word is the last one in range
      logic bit_set;     // block to free is marked used
   } sts_type;

endpackage

// File: hw/rtl/bba_ctrl.sv
module bba_ctrl
   import bba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_SCAN,
      S_FREE_CHK
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.resp_status = ST_OK;
      req_ready       = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.mode) begin
               if (sts.invalid) begin
                  if (sts.slot_free) begin
                     cmd.resp_load   = 1'b1;
                     cmd.resp_status = ST_INVALID_BLOCK;
                     state_in        = S_IDLE;
                  end
               end else begin
                  cmd.rd   = 1'b1;
                  state_in = S_FREE_CHK;
               end
            end else begin
               if (sts.alloc_empty) begin
                  if (sts.slot_free) begin
                     cmd.resp_load   = 1'b1;
                     cmd.resp_status = ST_NO_SPACE;
                     state_in        = S_IDLE;
                  end
               end else begin
                  cmd.rd   = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               if (sts.slot_free) begin
                  cmd.alloc_commit = 1'b1;
                  cmd.resp_load    = 1'b1;
                  cmd.resp_status  = ST_OK;
                  state_in         = S_IDLE;
               end
            end else if (sts.scan_last) begin
               if (sts.slot_free) begin
                  cmd.resp_load   = 1'b1;
                  cmd.resp_status = ST_NO_SPACE;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_FREE_CHK: begin
            if (sts.slot_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
               if (sts.bit_set) begin
                  cmd.free_commit = 1'b1;
                  cmd.resp_status = ST_OK;
               end else begin
                  cmd.resp_status = ST_ALREADY_FREE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // no result is produced while the bitmap is still being cleared
   a_no_resp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !cmd.resp_load)
      else $error("result issued during bitmap clear");

   // a scan always ends in a result before a new word is taken
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && state_in == S_IDLE |-> cmd.resp_load)
      else $error("scan left without result");

   // every accepted word is followed by a start step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_START)
      else $error("accepted word not started");
`endif

endmodule

// File: hw/rtl/bba_datapath.sv
module bba_datapath
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request payload
   input  logic                req_mode,
   input  logic [BLK_W-1:0]    req_block_number,
   // result
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output status_type          rsp_status,
   output logic [BLK_W-1:0]    rsp_allocated_block,
   output logic [CFG_W-1:0]    rsp_free_count,
   // configuration
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_data,
   // control
   input  cmd_type             cmd,
   output sts_type             sts
);

   localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SW        = $clog2(WORD_BITS);   // WORD_BITS is a power of two

   // configuration
   logic [CFG_W-1:0] nblk_ff, nblk_in;
   logic [CFG_W-1:0] first_ff, first_in;
   logic [CFG_W-1:0] free_cnt_ff, free_cnt_in;

   // request context
   logic             mode_ff;
   logic [SW-1:0]    blk_bit_ff;
   logic [CFG_W-1:0] n_m1_ff;
   logic [AW-1:0]    first_word_ff, last_word_ff;
   logic             alloc_empty_ff, invalid_ff;

   // bitmap memory and scan
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr_ff;
   logic [AW-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]        clr_ptr_ff;

   // result register
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [BLK_W-1:0] rsp_block_ff;
   logic [CFG_W-1:0] rsp_count_ff;

   logic [CFG_W-1:0]     n_eff;
   logic [SW-1:0]        lo_bit, hi_bit;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, cand, lowest, bit_mask;
   logic [SW-1:0]        hit_idx;
   logic [BLK_W-1:0]     granted;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // block count clamped to capacity
   always_comb begin
      if (32'(nblk_ff) > MAX_BLOCKS) begin
         n_eff = CFG_W'(MAX_BLOCKS);
      end else begin
         n_eff = nblk_ff;
      end
   end

   // in-range mask for the word under test, lowest clear bit within it
   always_comb begin
      lo_bit  = (rd_addr_ff == first_word_ff) ? first_ff[SW-1:0] : '0;
      hi_bit  = (rd_addr_ff == last_word_ff) ? n_m1_ff[SW-1:0] : SW'(WORD_BITS - 1);
      lo_mask = {WORD_BITS{1'b1}} << lo_bit;
      hi_mask = {WORD_BITS{1'b1}} >> (SW'(WORD_BITS - 1) - hi_bit);
      cand    = ~rd_data_ff & lo_mask & hi_mask;
      lowest  = cand & (~cand + 1'b1);
      hit_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lowest[j]) begin
            hit_idx = hit_idx | SW'(j);
         end
      end
      granted  = BLK_W'({rd_addr_ff, hit_idx});
      bit_mask = WORD_BITS'(1) << blk_bit_ff;
   end

   always_comb begin
      sts.clr_last    = (clr_ptr_ff == AW'(NUM_WORDS - 1));
      sts.slot_free   = !rsp_valid_ff || rsp_ready;
      sts.mode        = mode_ff;
      sts.alloc_empty = alloc_empty_ff;
      sts.invalid     = invalid_ff;
      sts.hit         = |cand;
      sts.scan_last   = (rd_addr_ff == last_word_ff);
      sts.bit_set     = |(rd_data_ff & bit_mask);
   end

   // memory write port
   always_comb begin
      wr_en   = cmd.clr || cmd.alloc_commit || cmd.free_commit;
      wr_addr = cmd.clr ? clr_ptr_ff : rd_addr_ff;
      if (cmd.clr) begin
         wr_data = '0;
      end else if (cmd.alloc_commit) begin
         wr_data = rd_data_ff | lowest;
      end else begin
         wr_data = rd_data_ff & ~bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[scan_ptr_ff];
         rd_addr_ff <= scan_ptr_ff;
      end
   end

   // configuration and free counter
   always_comb begin
      nblk_in     = nblk_ff;
      first_in    = first_ff;
      free_cnt_in = free_cnt_ff;
      if (cmd.alloc_commit) begin
         free_cnt_in = free_cnt_ff - 1'b1;
      end else if (cmd.free_commit && free_cnt_ff != FREE_COUNT_MAX) begin
         free_cnt_in = free_cnt_ff + 1'b1;
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_BLOCKS:         nblk_in     = csr_data;
            CSR_DATA_START:         first_in    = csr_data;
            CSR_INITIAL_FREE_COUNT: free_cnt_in = csr_data;
            default:                ;
         endcase
      end
   end

   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      if (cmd.load_req) begin
         scan_ptr_in = req_mode ? AW'(req_block_number >> SW) : AW'(first_ff >> SW);
      end else if (cmd.rd) begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nblk_ff      <= NUM_BLOCKS_RST;
         first_ff     <= FIRST_DATA_RST;
         free_cnt_ff  <= FREE_COUNT_RST;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nblk_ff     <= nblk_in;
         first_ff    <= first_in;
         free_cnt_ff <= free_cnt_in;
         if (cmd.clr) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request context and result payload
   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      if (cmd.load_req) begin
         mode_ff        <= req_mode;
         blk_bit_ff     <= req_block_number[SW-1:0];
         n_m1_ff        <= n_eff - 1'b1;
         first_word_ff  <= AW'(first_ff >> SW);
         last_word_ff   <= AW'((n_eff - 1'b1) >> SW);
         alloc_empty_ff <= (free_cnt_ff == '0) || (first_ff >= n_eff);
         invalid_ff     <= ({1'b0, req_block_number} >= n_eff);
      end
      if (cmd.resp_load) begin
         rsp_status_ff <= cmd.resp_status;
         rsp_block_ff  <= cmd.alloc_commit ? granted : '0;
         rsp_count_ff  <= free_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_free_count      = rsp_count_ff;

`ifndef ASSERT_OFF
   // result register is never overwritten while holding an untaken word
   a_resp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // allocation only commits on a found clear bit with a nonzero counter
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> (sts.hit && free_cnt_ff != '0 && !mode_ff))
      else $error("bad allocate commit");

   // free only commits on a valid, used block
   a_free_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.free_commit |-> (sts.bit_set && !invalid_ff && mode_ff))
      else $error("bad free commit");

   // a granted block lies inside the search range
   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> ({1'b0, granted} >= first_ff && n_m1_ff >= {1'b0, granted}))
      else $error("granted block out of range");
`endif

endmodule

// File: hw/rtl/bitmap_block_allocator_unit.sv
// First-fit bitmap block allocator. One used/free bit per block lives in a
// single-port bitmap memory of MAX_BLOCKS/WORD_BITS words, plus a 13-bit free
// counter. After reset the unit clears the bitmap one word per cycle and
// holds req_ready low meanwhile; csr writes are taken at all times. One
// request is worked at a time. An allocate scans bitmap words one per cycle
// from the word holding the first data block, after a start step, until a
// clear bit in range or the last word; a free reads the word of its block,
// then checks the bit; requests rejected up front are answered from the
// start step. The result sits in an output register, so the next request
// word is taken while a result waits; the unit only stalls when a new result
// is ready and the old one has not been taken. Writing initial_free_count
// also loads the free counter at once. Configure only while idle.
module bitmap_block_allocator_unit
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [BLK_W-1:0] req_block_number,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output status_type       rsp_status,
   output logic [BLK_W-1:0] rsp_allocated_block,
   output logic [CFG_W-1:0] rsp_free_count,
   // register write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencing: clear pass, request decode, word scan, commit
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // bitmap memory, counters, search logic, result register
   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_free_count      (rsp_free_count),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

// File: tb/tb_bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_unit;
   import bba_pkg::*;

   // request mode encoding
   localparam logic MODE_ALLOCATE = 1'b0;
   localparam logic MODE_FREE     = 1'b1;

   // register index with no register behind it
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int unsigned TARGET_REQUESTS = 1050;
   // longest stretch without any handshake: clear pass after reset,
   // full-range scan, long sender gap and long result stall
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   // quiet time after the last result, a bit over one worst-case scan
   localparam int unsigned DRAIN_CYCLES    = 200;

   typedef struct packed {
      status_type       status;
      logic [BLK_W-1:0] block;
      logic [CFG_W-1:0] free_count;
   } result_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = MODE_ALLOCATE;
   logic [BLK_W-1:0] req_block_number = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   status_type       rsp_status;
   logic [BLK_W-1:0] rsp_allocated_block;
   logic [CFG_W-1:0] rsp_free_count;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   bitmap_block_allocator_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_free_count      (rsp_free_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow allocator state: bitmap, counter, the two layout registers.
   // ---------------------------------------------------------------------
   bit               used_map [MAX_BLOCKS_DEF];
   logic [CFG_W-1:0] model_free_left     = FREE_COUNT_RST;
   logic [CFG_W-1:0] model_num_blocks    = NUM_BLOCKS_RST;
   logic [CFG_W-1:0] model_first_data    = FIRST_DATA_RST;

   // blocks currently marked used, so frees can target real allocations
   int unsigned      held_blocks [$];
   // results owed by the DUT, oldest first
   result_word_type  pending_results [$];

   int unsigned      error_count = 0;
   int unsigned      requests_sent = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      rsp_hold = 0;
   bit               quiet_stretch = 1'b0;   // no idling on either side
   bit               req_held = 1'b0;        // req_valid was raised and not yet lowered

   // block count above capacity acts as capacity
   function automatic int unsigned active_block_limit();
      return (model_num_blocks > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : model_num_blocks;
   endfunction

   // Apply one request to the shadow state and return the word it must produce.
   function automatic result_word_type compute_request_result(input logic mode,
                                                              input logic [BLK_W-1:0] blk);
      result_word_type res;
      int unsigned     span_end;
      int unsigned     b;
      int unsigned     idx;
      span_end   = active_block_limit();
      res.status = ST_OK;
      res.block  = '0;
      if (mode == MODE_ALLOCATE) begin
         if (model_free_left == 0) begin
            res.status = ST_NO_SPACE;
         end else begin
            // first fit from the first data block; empty range if it is past the end
            b = model_first_data;
            while (b < span_end && used_map[b])
               b++;
            if (b >= span_end) begin
               res.status = ST_NO_SPACE;
            end else begin
               used_map[b]     = 1'b1;
               model_free_left = model_free_left - 1'b1;
               res.block       = b[BLK_W-1:0];
               held_blocks.push_back(b);
            end
         end
      end else begin
         if (blk >= span_end) begin
            res.status = ST_INVALID_BLOCK;
         end else if (!used_map[blk]) begin
            res.status = ST_ALREADY_FREE;
         end else begin
            used_map[blk] = 1'b0;
            // counter saturates at all ones
            if (model_free_left != FREE_COUNT_MAX)
               model_free_left = model_free_left + 1'b1;
            for (idx = 0; idx < held_blocks.size(); idx++) begin
               if (held_blocks[idx] == blk) begin
                  held_blocks.delete(idx);
                  break;
               end
            end
         end
      end
      res.free_count = model_free_left;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid stays up across back-to-back words; it only drops
   // for a gap or when the sender waits for the DUT to drain.
   // ---------------------------------------------------------------------
   task automatic issue_request(input logic mode, input logic [BLK_W-1:0] blk);
      result_word_type want;
      int unsigned     gap;
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_block_number <= blk;
      req_held          = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      want = compute_request_result(mode, blk);
      pending_results.push_back(want);
      requests_sent++;
      gap = quiet_stretch ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_held   = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed word has come back.
   task automatic wait_for_results();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held   = 1'b0;
      end
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // One register write; csr_valid stays up unless this is the last of a burst.
   task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data,
                                 input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_NUM_BLOCKS:         model_num_blocks = data;
         CSR_DATA_START:         model_first_data = data;
         CSR_INITIAL_FREE_COUNT: begin
            // also loads the live counter
            model_free_left = data;
         end
         default: ;
      endcase
      if (last)
         csr_valid <= 1'b0;
   endtask

   // Full reconfiguration, only once the DUT is idle.
   task automatic set_layout(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] first,
                             input logic [CFG_W-1:0] initial_free);
      wait_for_results();
      write_register(CSR_NUM_BLOCKS, count, 1'b0);
      write_register(CSR_DATA_START, first, 1'b0);
      write_register(CSR_INITIAL_FREE_COUNT, initial_free, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random backpressure, checker, watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (!quiet_stretch && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got status %0d block %0d count %0d",
                     $time, rsp_status, rsp_allocated_block, rsp_free_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("status", want.status, rsp_status);
            report_field("allocated_block", want.block, rsp_allocated_block);
            report_field("free_count", want.free_count, rsp_free_count);
         end
      end
   end

   // Any handshake counts as progress; the clear pass after reset is covered
   // by the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Default registers: full range, counter 4096.
   task automatic test_reset_defaults();
      issue_request(MODE_ALLOCATE, '0);          // gets block 0
      issue_request(MODE_ALLOCATE, 12'hFFF);     // block number ignored, gets 1
      issue_request(MODE_FREE, 12'd0);
      issue_request(MODE_FREE, 12'd0);           // double free
      issue_request(MODE_FREE, 12'hFFF);         // top block, never used
      issue_request(MODE_ALLOCATE, '0);          // lowest clear bit again: 0
   endtask

   // Search window edges: oversized count, window at the top, empty windows.
   task automatic test_range_limits();
      // count above capacity clamps to 4096; counter load with bit 12 set
      set_layout(13'h1FFF, 13'd4094, 13'd8190);
      issue_request(MODE_ALLOCATE, '0);          // 4094
      issue_request(MODE_ALLOCATE, '0);          // 4095, all ones granted
      issue_request(MODE_ALLOCATE, '0);          // window used up, counter nonzero
      issue_request(MODE_FREE, 12'hFFF);
      issue_request(MODE_FREE, 12'd1);           // below first data block is fine
      // zero blocks: everything is out of range
      set_layout(13'd0, 13'd0, 13'd100);
      issue_request(MODE_FREE, 12'd0);
      issue_request(MODE_ALLOCATE, '0);
      // first data block equal to block count
      set_layout(13'd4096, 13'd4096, 13'd100);
      issue_request(MODE_ALLOCATE, '0);
      issue_request(MODE_FREE, 12'd4094);
   endtask

   // Counter zero, counter out of step with the bitmap, spare index, saturation.
   task automatic test_counter_edges();
      set_layout(13'd100, 13'd10, 13'd0);
      issue_request(MODE_ALLOCATE, '0);          // counter zero
      issue_request(MODE_FREE, 12'd100);         // at block count
      issue_request(MODE_FREE, 12'd10);          // clear bit
      wait_for_results();
      write_register(CSR_INITIAL_FREE_COUNT, 13'd1, 1'b1);
      issue_request(MODE_ALLOCATE, '0);          // 10, counter to zero
      issue_request(MODE_ALLOCATE, '0);          // clear bits left, counter says none
      issue_request(MODE_FREE, 12'd10);
      wait_for_results();
      write_register(CSR_SPARE_INDEX, 13'h1FFF, 1'b1);
      issue_request(MODE_ALLOCATE, '0);          // write above must not have landed
      wait_for_results();
      write_register(CSR_INITIAL_FREE_COUNT, FREE_COUNT_MAX, 1'b1);
      issue_request(MODE_FREE, 12'd10);          // counter stays at max
   endtask

   // ---------------------------------------------------------------------
   // Random traffic: phases of random layout, mostly well-formed
   // allocate/free mixes with some stray frees.
   // ---------------------------------------------------------------------
   task automatic test_random_traffic();
      int unsigned sel;
      int unsigned span;
      int unsigned base;
      int unsigned count;
      int unsigned first;
      int unsigned initial_free;
      int unsigned phase_len;
      int unsigned r;
      int unsigned top;
      int unsigned idx;
      int unsigned blk;
      int unsigned doomed [$];
      while (requests_sent < TARGET_REQUESTS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            // small window, at the bottom or anywhere, often crossing words
            span         = $urandom_range(8, 200);
            base         = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3800);
            count        = base + span;
            first        = base + $urandom_range(0, span - 1);
            initial_free = $urandom_range(0, span + 8);
         end else if (sel < 8) begin
            // window at the top of the map: high block numbers
            count        = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
            first        = 4096 - $urandom_range(8, 120);
            initial_free = ($urandom_range(0, 4) == 0) ? FREE_COUNT_MAX
                                                       : $urandom_range(0, 130);
         end else if (sel == 8) begin
            count        = 4096;
            first        = 0;
            initial_free = $urandom_range(0, 4096);
         end else begin
            // first data block at or past block count
            count        = $urandom_range(0, 300);
            first        = $urandom_range(0, 1) ? 8191 : count + $urandom_range(0, 100);
            initial_free = $urandom_range(0, 8191);
         end
         set_layout(CFG_W'(count), CFG_W'(first), CFG_W'(initial_free));
         quiet_stretch = ($urandom_range(0, 3) == 0);
         phase_len     = $urandom_range(30, 90);
         repeat (phase_len) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               issue_request(MODE_ALLOCATE, BLK_W'($urandom_range(0, 4095)));
            end else if (r < 85 && held_blocks.size() != 0) begin
               idx = $urandom_range(0, held_blocks.size() - 1);
               issue_request(MODE_FREE, BLK_W'(held_blocks[idx]));
            end else if (r < 93) begin
               top = active_block_limit() + 4;
               if (top > 4095)
                  top = 4095;
               issue_request(MODE_FREE, BLK_W'($urandom_range(0, top)));
            end else begin
               issue_request(MODE_FREE, BLK_W'($urandom_range(0, 4095)));
            end
            // sender holds off until the DUT has drained
            if ($urandom_range(0, 19) == 0)
               wait_for_results();
         end
         // sometimes hand back everything in range, in random order
         if ($urandom_range(0, 1) == 1) begin
            doomed = held_blocks;
            while (doomed.size() != 0) begin
               idx = $urandom_range(0, doomed.size() - 1);
               blk = doomed[idx];
               doomed.delete(idx);
               if (blk < active_block_limit())
                  issue_request(MODE_FREE, BLK_W'(blk));
            end
         end
      end
      quiet_stretch = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // first request waits out the bitmap clear pass via req_ready
      test_reset_defaults();
      test_range_limits();
      test_counter_edges();
      test_random_traffic();
      wait_for_results();
      // catch any stray word after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
